FILE: sv/lts_pkg.sv
`default_nettype none
package lts_pkg;

    localparam int DIST_W = 17;
    localparam int ECHO_W = 15;
    localparam int BAND_W = 12;
    localparam int THR_W  = 16;
    localparam int CFG_W  = 16;
    localparam int PROD_W = 26;

    // 0.017 cm/us in Q16
    localparam logic [10:0]       ECHO_MUL = 11'd1114;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [BAND_W-1:0] BAND_RST = 12'd128;
    localparam logic [THR_W-1:0]  THR_RST  = 16'd1536;

    typedef enum logic [3:0] {
        REQ_PWR_ON  = 4'd0,
        REQ_PWR_OFF = 4'd1,
        REQ_MANUAL  = 4'd2,
        REQ_AUTO    = 4'd3,
        REQ_UP      = 4'd4,
        REQ_DOWN    = 4'd5,
        REQ_FAST    = 4'd6,
        REQ_STOP    = 4'd7,
        REQ_GOTO    = 4'd8,
        REQ_TICK    = 4'd9
    } t_req_type;

    typedef enum logic [0:0] {
        CFG_BAND = 1'd0,
        CFG_THR  = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        SPD_NONE = 2'd0,
        SPD_SLOW = 2'd1,
        SPD_FAST = 2'd2
    } t_speed;

    // request after the input stage, distance already converted
    typedef struct packed {
        logic [3:0]        req;
        logic [DIST_W-1:0] tgt;
        logic [DIST_W-1:0] distance;
        logic              echo_nz;
    } t_item;

    typedef struct packed {
        logic              relay_up;
        logic              relay_down;
        logic              relay_fast;
        logic              powered;
        logic              manual_mode;
        logic [1:0]        direction;
        logic [1:0]        speed;
        logic [DIST_W-1:0] current_distance;
        logic              target_valid;
        logic [DIST_W-1:0] target_out;
    } t_status;

endpackage
`default_nettype wire

FILE: sv/lts_front.sv
`default_nettype none
module lts_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [3:0]                i_req,
    input  wire logic [lts_pkg::DIST_W-1:0] i_tgt,
    input  wire logic [lts_pkg::ECHO_W-1:0] i_echo,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output lts_pkg::t_item                 o_item
);

    logic [lts_pkg::PROD_W-1:0] w_prod;
    logic [lts_pkg::PROD_W-9:0] w_q;
    logic [lts_pkg::DIST_W-1:0] w_dist;
    logic                       r_vld;
    lts_pkg::t_item             r_item;

    // echo_us * 1114 >> 8, saturated to the 17-bit range
    assign w_prod = lts_pkg::PROD_W'(i_echo) * lts_pkg::PROD_W'(lts_pkg::ECHO_MUL);
    assign w_q    = w_prod[lts_pkg::PROD_W-1:8];
    assign w_dist = w_q[lts_pkg::DIST_W] ? lts_pkg::DIST_MAX : w_q[lts_pkg::DIST_W-1:0];

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.req      <= i_req;
            r_item.tgt      <= i_tgt;
            r_item.distance <= w_dist;
            r_item.echo_nz  <= (i_echo != '0);
        end
    end

endmodule
`default_nettype wire

FILE: sv/lts_core.sv
`default_nettype none
module lts_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [0:0]                i_cfg_idx,
    input  wire logic [lts_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire lts_pkg::t_item            i_item,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output lts_pkg::t_status               o_status
);

    logic [lts_pkg::BAND_W-1:0] r_band;
    logic [lts_pkg::THR_W-1:0]  r_thr;
    logic                       r_out_vld;
    logic                       r_power, n_power;
    logic                       r_manual, n_manual;
    lts_pkg::t_dir              r_dir, n_dir;
    lts_pkg::t_speed            r_speed, n_speed;
    logic [lts_pkg::DIST_W-1:0] r_dist, n_dist;
    logic                       r_pend, n_pend;
    logic [lts_pkg::DIST_W-1:0] r_tgt, n_tgt;
    logic                       w_adv;
    logic                       w_man_ok;
    logic                       w_up;
    logic [lts_pkg::DIST_W-1:0] w_err;
    logic [lts_pkg::DIST_W-1:0] w_tick_dist;

    assign o_ready  = !r_out_vld || i_ready;
    assign w_adv    = i_valid && o_ready;
    assign w_man_ok = r_power && r_manual;

    // error against the distance this tick leaves behind
    assign w_tick_dist = i_item.echo_nz ? i_item.distance : r_dist;
    assign w_up        = r_tgt > w_tick_dist;
    assign w_err       = w_up ? (r_tgt - w_tick_dist) : (w_tick_dist - r_tgt);

    always_comb begin
        n_power  = r_power;
        n_manual = r_manual;
        n_dir    = r_dir;
        n_speed  = r_speed;
        n_dist   = r_dist;
        n_pend   = r_pend;
        n_tgt    = r_tgt;
        case (lts_pkg::t_req_type'(i_item.req))
            lts_pkg::REQ_PWR_ON: begin
                n_power = 1'b1;
            end
            lts_pkg::REQ_PWR_OFF: begin
                n_power = 1'b0;
                n_dir   = lts_pkg::DIR_STOP;
                n_speed = lts_pkg::SPD_NONE;
                n_pend  = 1'b0;
            end
            lts_pkg::REQ_MANUAL: begin
                n_manual = 1'b1;
                n_pend   = 1'b0;
            end
            lts_pkg::REQ_AUTO: begin
                n_manual = 1'b0;
                n_dir    = lts_pkg::DIR_STOP;
                n_speed  = lts_pkg::SPD_NONE;
            end
            lts_pkg::REQ_UP, lts_pkg::REQ_DOWN: begin
                if (w_man_ok) begin
                    n_pend  = 1'b0;
                    n_dir   = (i_item.req == lts_pkg::REQ_UP) ? lts_pkg::DIR_UP
                                                              : lts_pkg::DIR_DOWN;
                    n_speed = lts_pkg::SPD_SLOW;
                end
            end
            lts_pkg::REQ_FAST: begin
                if (w_man_ok && r_dir != lts_pkg::DIR_STOP) begin
                    n_speed = lts_pkg::SPD_FAST;
                end
            end
            lts_pkg::REQ_STOP: begin
                if (w_man_ok) begin
                    n_dir   = lts_pkg::DIR_STOP;
                    n_speed = lts_pkg::SPD_NONE;
                    n_pend  = 1'b0;
                end
            end
            lts_pkg::REQ_GOTO: begin
                if (r_power && !r_manual) begin
                    n_tgt  = i_item.tgt;
                    n_pend = 1'b1;
                end
            end
            lts_pkg::REQ_TICK: begin
                n_dist = w_tick_dist;
                if (r_pend && r_power && !r_manual) begin
                    if (w_err <= lts_pkg::DIST_W'(r_band)) begin
                        n_dir   = lts_pkg::DIR_STOP;
                        n_speed = lts_pkg::SPD_NONE;
                        n_pend  = 1'b0;
                    end else begin
                        n_dir   = w_up ? lts_pkg::DIR_UP : lts_pkg::DIR_DOWN;
                        n_speed = (w_err > lts_pkg::DIST_W'(r_thr)) ? lts_pkg::SPD_FAST
                                                                    : lts_pkg::SPD_SLOW;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band <= lts_pkg::BAND_RST;
            r_thr  <= lts_pkg::THR_RST;
        end else if (i_cfg_we) begin
            case (lts_pkg::t_cfg_idx'(i_cfg_idx))
                lts_pkg::CFG_BAND: r_band <= i_cfg_data[lts_pkg::BAND_W-1:0];
                lts_pkg::CFG_THR:  r_thr  <= i_cfg_data[lts_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // the state registers double as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_power   <= 1'b0;
            r_manual  <= 1'b1;
            r_dir     <= lts_pkg::DIR_STOP;
            r_speed   <= lts_pkg::SPD_NONE;
            r_dist    <= '0;
            r_pend    <= 1'b0;
            r_tgt     <= '0;
        end else begin
            if (o_ready) begin
                r_out_vld <= i_valid;
            end
            if (w_adv) begin
                r_power  <= n_power;
                r_manual <= n_manual;
                r_dir    <= n_dir;
                r_speed  <= n_speed;
                r_dist   <= n_dist;
                r_pend   <= n_pend;
                r_tgt    <= n_tgt;
            end
        end
    end

    assign o_valid                   = r_out_vld;
    assign o_status.relay_up         = (r_dir == lts_pkg::DIR_UP);
    assign o_status.relay_down       = (r_dir == lts_pkg::DIR_DOWN);
    assign o_status.relay_fast       = (r_speed == lts_pkg::SPD_FAST);
    assign o_status.powered          = r_power;
    assign o_status.manual_mode      = r_manual;
    assign o_status.direction        = r_dir;
    assign o_status.speed            = r_speed;
    assign o_status.current_distance = r_dist;
    assign o_status.target_valid     = r_pend;
    assign o_status.target_out       = r_pend ? r_tgt : '0;

    a_dir_speed_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir == lts_pkg::DIR_STOP) == (r_speed == lts_pkg::SPD_NONE))
        else $error("direction and speed disagree");

    a_off_is_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_power |-> (r_dir == lts_pkg::DIR_STOP))
        else $error("motor runs without power");

    a_pend_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (!r_manual && r_power))
        else $error("target pending outside powered auto mode");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("advanced request produced no result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> ($stable(r_dist) && $stable(r_dir) && $stable(r_pend)))
        else $error("state moved while result stalled");

endmodule
`default_nettype wire

FILE: sv/lift_two_speed_positioner_top.sv
// Path: an accepted request is registered in the input stage, then in the state stage, which holds its status result.
// Throughput: one request per cycle; the output register is the state itself, so a stall
//   on the master side holds both stages and back-pressures the slave side.
// Reset (i_rst_n low, synchronous): power off, manual mode, motor stopped, distance 0,
//   no target, arrive_band 128, fast_threshold 1536, both stages empty.
`default_nettype none
module lift_two_speed_positioner_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration: index 0 arrive_band, 1 fast_threshold
    input  wire logic                        i_cfg_we,
    input  wire logic [0:0]                  i_cfg_idx,
    input  wire logic [lts_pkg::CFG_W-1:0]   i_cfg_data,
    // request stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [31:0]                 s_axis_tdata,  // target_distance[16:0], echo_time_us[31:17]
    input  wire logic [3:0]                  s_axis_tuser,  // req_type[3:0]
    // status stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // relay_up[0], relay_down[1], relay_fast[2], powered[3], manual_mode[4], direction[6:5],
    // speed[8:7], current_distance[25:9], target_valid[26], target_out[43:27], zero[47:44]
    output logic [47:0]                      m_axis_tdata
);

    logic             w_front_vld;
    logic             w_core_rdy;
    lts_pkg::t_item   w_item;
    lts_pkg::t_status w_status;

    // input stage: registers the request and converts the echo width to cm Q8
    lts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (s_axis_tuser),
        .i_tgt   (s_axis_tdata[16:0]),
        .i_echo  (s_axis_tdata[31:17]),
        .o_valid (w_front_vld),
        .i_ready (w_core_rdy),
        .o_item  (w_item)
    );

    // state stage: applies the request to the lift state, which is the result
    lts_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (w_front_vld),
        .o_ready    (w_core_rdy),
        .i_item     (w_item),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (w_status)
    );

    assign m_axis_tdata = {4'b0000,
                           w_status.target_out,
                           w_status.target_valid,
                           w_status.current_distance,
                           w_status.speed,
                           w_status.direction,
                           w_status.manual_mode,
                           w_status.powered,
                           w_status.relay_fast,
                           w_status.relay_down,
                           w_status.relay_up};

endmodule
`default_nettype wire
